FILE: src/atinterp_pkg.sv
// Shared constants, types and breakpoint tables for the attenuation table interpolator.
`default_nettype none

package atinterp_pkg;

    localparam int TABLE_ENTRIES = 12;
    localparam int FRACTION_BITS = 16;
    localparam int DIST_W        = 16;
    localparam int COEF_W        = 31;
    localparam int NUM_COEF      = 3;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    // Coefficient slots within one row
    localparam int COEF_CONSTANT  = 0;
    localparam int COEF_LINEAR    = 1;
    localparam int COEF_QUADRATIC = 2;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [DIST_W-1:0] t_dist;
    typedef logic [COEF_W-1:0] t_coef;
    typedef logic [NUM_COEF-1:0][COEF_W-1:0] t_coef_set;

    // Breakpoints in Q12.4, ascending
    localparam t_dist DIST_TABLE [TABLE_ENTRIES] = '{
        16'd112,  16'd208,  16'd320,  16'd512,  16'd800,  16'd1040,
        16'd1600, 16'd2560, 16'd3200, 16'd5200, 16'd9600, 16'd52000
    };

    // Coefficients in Q1.30: constant, linear, quadratic
    localparam t_coef COEF_TABLE [TABLE_ENTRIES][NUM_COEF] = '{
        '{31'd1073741824, 31'd751619277, 31'd1932735283},
        '{31'd1073741824, 31'd375809638, 31'd472446403},
        '{31'd1073741824, 31'd236223201, 31'd214748365},
        '{31'd1073741824, 31'd150323855, 31'd75161928},
        '{31'd1073741824, 31'd96636764,  31'd34359738},
        '{31'd1073741824, 31'd75161928,  31'd18253611},
        '{31'd1073741824, 31'd48318382,  31'd8053064},
        '{31'd1073741824, 31'd28991029,  31'd3006477},
        '{31'd1073741824, 31'd23622320,  31'd2040109},
        '{31'd1073741824, 31'd15032386,  31'd751619},
        '{31'd1073741824, 31'd7516193,   31'd214748},
        '{31'd1073741824, 31'd1503239,   31'd7516}
    };

endpackage

`default_nettype wire

FILE: src/attenuation_table_interp_unit.sv
// Top level of the attenuation table interpolator: search, divide, multiply, combine pipeline.
`default_nettype none

// Maps a light range (unsigned Q12.4) to constant, linear and quadratic
// attenuation coefficients (unsigned Q1.30) by piecewise linear
// interpolation over a built-in table of twelve breakpoints (7.0 to 3250.0).
// Ranges at or below the first breakpoint return the first row, ranges at or
// above the last breakpoint return the last row. The unit is a fully
// pipelined datapath: an input register, a segment search stage, a table
// lookup stage, one restoring-division stage per fraction bit of the segment
// position t, a multiply stage and a combine stage that feeds the output
// register. A new transaction is accepted every cycle while the output is
// taken; when the output is held, the whole pipeline holds with it and
// o_in_ready drops, so no transaction is lost or repeated.
module attenuation_table_interp_unit #(
    parameter int FRACTION_BITS = atinterp_pkg::FRACTION_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [atinterp_pkg::DIST_W-1:0]   i_distance_q,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [atinterp_pkg::COEF_W-1:0]        o_constant_q,
    output logic [atinterp_pkg::COEF_W-1:0]        o_linear_q,
    output logic [atinterp_pkg::COEF_W-1:0]        o_quadratic_q
);

    localparam int N      = atinterp_pkg::TABLE_ENTRIES;
    localparam int DW     = atinterp_pkg::DIST_W;
    localparam int CW     = atinterp_pkg::COEF_W;
    localparam int NC     = atinterp_pkg::NUM_COEF;
    localparam int IW     = atinterp_pkg::IDX_W;
    localparam int PROD_W = FRACTION_BITS + CW;

    // Global advance: every stage moves when the output register is free or taken
    logic w_adv;

    // Stage A: input register
    logic                    r_a_valid;
    atinterp_pkg::t_dist     r_a_dist;

    // Stage B: segment search
    logic                    r_b_valid;
    atinterp_pkg::t_dist     r_b_dist;
    atinterp_pkg::t_idx      r_b_idx;
    logic                    r_b_clamp;
    atinterp_pkg::t_idx      n_b_idx;
    logic                    n_b_under;
    logic                    n_b_over;

    // Stage C (index 0) and the divider stages (1..FRACTION_BITS)
    logic                       r_d_valid [FRACTION_BITS+1];
    atinterp_pkg::t_dist        r_d_rem   [FRACTION_BITS+1];
    atinterp_pkg::t_dist        r_d_den   [FRACTION_BITS+1];
    logic [FRACTION_BITS-1:0]   r_d_quo   [FRACTION_BITS+1];
    atinterp_pkg::t_coef_set    r_d_p0    [FRACTION_BITS+1];
    atinterp_pkg::t_coef_set    r_d_mag   [FRACTION_BITS+1];
    logic [NC-1:0]              r_d_neg   [FRACTION_BITS+1];

    atinterp_pkg::t_idx         w_c_next_idx;
    atinterp_pkg::t_dist        w_c_d0;
    atinterp_pkg::t_dist        w_c_d1;
    atinterp_pkg::t_coef_set    n_c_p0;
    atinterp_pkg::t_coef_set    n_c_mag;
    logic [NC-1:0]              n_c_neg;

    // Stage M: products
    logic                       r_m_valid;
    logic [NC-1:0][PROD_W-1:0]  r_m_prod;
    atinterp_pkg::t_coef_set    r_m_p0;
    logic [NC-1:0]              r_m_neg;

    // Combine and output register
    logic [NC-1:0][CW:0]        w_e_sum;
    atinterp_pkg::t_coef_set    n_e_coef;
    logic                       r_out_valid;
    atinterp_pkg::t_coef_set    r_out_coef;

    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    // ---------------------------------------------------------------
    // Stage A: capture the transaction
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= i_in_valid;
        end
        if (w_adv) begin
            r_a_dist <= i_distance_q;
        end
    end

    // ---------------------------------------------------------------
    // Stage B: find the segment with d0 <= range < d1, or clamp to an end row
    // ---------------------------------------------------------------
    always_comb begin
        n_b_under = (r_a_dist <= atinterp_pkg::DIST_TABLE[0]);
        n_b_over  = (r_a_dist >= atinterp_pkg::DIST_TABLE[N-1]);
        n_b_idx   = '0;
        // Independent compares; the table is ascending so the last hit wins
        for (int i = 1; i < N - 1; i++) begin
            if (atinterp_pkg::DIST_TABLE[i] <= r_a_dist) begin
                n_b_idx = IW'(i);
            end
        end
        if (n_b_over) begin
            n_b_idx = IW'(N - 1);
        end
        if (n_b_under) begin
            n_b_idx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_adv) begin
            r_b_valid <= r_a_valid;
        end
        if (w_adv) begin
            r_b_dist  <= r_a_dist;
            r_b_idx   <= n_b_idx;
            r_b_clamp <= n_b_under || n_b_over;
        end
    end

    // ---------------------------------------------------------------
    // Stage C: read both rows, form numerator, divisor and coefficient deltas.
    // A clamped range gets a zero delta and t = 0, so it returns its row as is.
    // ---------------------------------------------------------------
    assign w_c_next_idx = r_b_clamp ? r_b_idx : (r_b_idx + IW'(1));
    assign w_c_d0       = atinterp_pkg::DIST_TABLE[r_b_idx];
    assign w_c_d1       = atinterp_pkg::DIST_TABLE[w_c_next_idx];

    always_comb begin
        for (int k = 0; k < NC; k++) begin
            n_c_p0[k] = atinterp_pkg::COEF_TABLE[r_b_idx][k];
            if (atinterp_pkg::COEF_TABLE[w_c_next_idx][k] >= n_c_p0[k]) begin
                n_c_neg[k] = 1'b0;
                n_c_mag[k] = atinterp_pkg::COEF_TABLE[w_c_next_idx][k] - n_c_p0[k];
            end else begin
                n_c_neg[k] = 1'b1;
                n_c_mag[k] = n_c_p0[k] - atinterp_pkg::COEF_TABLE[w_c_next_idx][k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid[0] <= 1'b0;
        end else if (w_adv) begin
            r_d_valid[0] <= r_b_valid;
        end
        if (w_adv) begin
            if (r_b_clamp) begin
                r_d_rem[0] <= '0;
                r_d_den[0] <= DW'(1);
            end else begin
                r_d_rem[0] <= r_b_dist - w_c_d0;
                r_d_den[0] <= w_c_d1 - w_c_d0;
            end
            r_d_quo[0] <= '0;
            r_d_p0[0]  <= n_c_p0;
            r_d_mag[0] <= n_c_mag;
            r_d_neg[0] <= n_c_neg;
        end
    end

    // ---------------------------------------------------------------
    // Divider: one restoring step per stage, most significant bit of t first.
    // The remainder stays below the divisor, so t fits FRACTION_BITS bits.
    // ---------------------------------------------------------------
    for (genvar j = 0; j < FRACTION_BITS; j++) begin : g_div
        logic [DW:0] w_rem2;
        logic [DW:0] w_diff;
        logic        w_ge;

        assign w_rem2 = {r_d_rem[j], 1'b0};
        assign w_diff = w_rem2 - {1'b0, r_d_den[j]};
        assign w_ge   = (w_rem2 >= {1'b0, r_d_den[j]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_valid[j+1] <= 1'b0;
            end else if (w_adv) begin
                r_d_valid[j+1] <= r_d_valid[j];
            end
            if (w_adv) begin
                r_d_rem[j+1] <= w_ge ? w_diff[DW-1:0] : w_rem2[DW-1:0];
                r_d_den[j+1] <= r_d_den[j];
                r_d_quo[j+1] <= {r_d_quo[j][FRACTION_BITS-2:0], w_ge};
                r_d_p0[j+1]  <= r_d_p0[j];
                r_d_mag[j+1] <= r_d_mag[j];
                r_d_neg[j+1] <= r_d_neg[j];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage M: t times the delta magnitude, one multiplier per coefficient
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_adv) begin
            r_m_valid <= r_d_valid[FRACTION_BITS];
        end
        if (w_adv) begin
            for (int k = 0; k < NC; k++) begin
                r_m_prod[k] <= PROD_W'(r_d_quo[FRACTION_BITS])
                             * PROD_W'(r_d_mag[FRACTION_BITS][k]);
            end
            r_m_p0  <= r_d_p0[FRACTION_BITS];
            r_m_neg <= r_d_neg[FRACTION_BITS];
        end
    end

    // ---------------------------------------------------------------
    // Combine: p0 + floor(t * delta / 2^FRACTION_BITS). A falling segment
    // rounds the magnitude up before subtracting, which floors the signed value.
    // ---------------------------------------------------------------
    always_comb begin
        logic [PROD_W:0]  v_up;
        logic [CW-1:0]    v_q;
        for (int k = 0; k < NC; k++) begin
            if (r_m_neg[k]) begin
                v_up = {1'b0, r_m_prod[k]} + (PROD_W + 1)'((1 << FRACTION_BITS) - 1);
                v_q  = v_up[PROD_W-1:FRACTION_BITS];
                w_e_sum[k] = {1'b0, r_m_p0[k]} - {1'b0, v_q};
                // Clamp at zero; the table keeps this from ever happening
                n_e_coef[k] = w_e_sum[k][CW] ? '0 : w_e_sum[k][CW-1:0];
            end else begin
                v_up = '0;
                v_q  = r_m_prod[k][PROD_W-1:FRACTION_BITS];
                w_e_sum[k] = {1'b0, r_m_p0[k]} + {1'b0, v_q};
                n_e_coef[k] = w_e_sum[k][CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_m_valid;
        end
        if (w_adv) begin
            r_out_coef <= n_e_coef;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_constant_q  = r_out_coef[atinterp_pkg::COEF_CONSTANT];
    assign o_linear_q    = r_out_coef[atinterp_pkg::COEF_LINEAR];
    assign o_quadratic_q = r_out_coef[atinterp_pkg::COEF_QUADRATIC];

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------

    // The divider sees a nonzero divisor and a partial remainder below it
    a_div_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_valid[0] |-> (r_d_den[0] != '0) && (r_d_rem[0] < r_d_den[0]))
        else $error("divider entry: remainder not below nonzero divisor");

    // The last restoring step leaves a remainder below the divisor
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_valid[FRACTION_BITS] |->
            (r_d_rem[FRACTION_BITS] < r_d_den[FRACTION_BITS]))
        else $error("divider exit: remainder not below divisor");

    // Interpolated values stay inside 31 bits and never go negative
    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> !w_e_sum[0][CW] && !w_e_sum[1][CW] && !w_e_sum[2][CW])
        else $error("interpolated coefficient out of range");

    // A held output freezes the pipeline: the result stays put across the stall
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid && $stable(r_out_coef))
        else $error("output changed while stalled");

endmodule

`default_nettype wire
